### hw/rtl/mmsc_pkg.sv
// Shared types, constants and gain functions of the multi-model switching controller.
package mmsc_pkg;

  localparam int DataW  = 32;
  localparam int OpW    = 3;
  localparam int ModelW = 2;

  // Signed width of 2*N + D; |N| stays below 19 * 2^31.
  localparam int NumW   = 39;
  // Width of the offset numerator before clamping.
  localparam int TW     = 40;
  // Clamped, offset numerator: below 25 * 2^32.
  localparam int UW     = 37;
  // Two-digit division of UW bits: high digit, low digit, remainder.
  localparam int SplitW = 18;
  localparam int HiW    = UW - SplitW;
  localparam int OddW   = 5;
  localparam int RemW   = 5;
  localparam int X2W    = RemW + SplitW;
  localparam int QhW    = 17;
  localparam int QlW    = 21;

  // Reciprocals ceil(2^28 / d); exact for dividends below 2^23.
  localparam int RecipW     = 26;
  localparam int RecipShift = 28;
  localparam logic [RecipW-1:0] Recip5  = RecipW'(53687092);
  localparam logic [RecipW-1:0] Recip25 = RecipW'(10737419);

  localparam logic [OpW-1:0] OpRef   = 3'd0;
  localparam logic [OpW-1:0] OpOut   = 3'd1;
  localparam logic [OpW-1:0] OpDeriv = 3'd2;
  localparam logic [OpW-1:0] OpErr1  = 3'd3;
  localparam logic [OpW-1:0] OpErr2  = 3'd4;
  localparam logic [OpW-1:0] OpErr3  = 3'd5;

  localparam logic [ModelW-1:0] Model1 = 2'd1;
  localparam logic [ModelW-1:0] Model2 = 2'd2;
  localparam logic [ModelW-1:0] Model3 = 2'd3;

  localparam int FlagRef   = 0;
  localparam int FlagOut   = 1;
  localparam int FlagDeriv = 2;

  typedef struct packed {
    logic                    valid;
    logic [OpW-1:0]          opcode;
    logic signed [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    valid;
    logic [ModelW-1:0]       model;
    logic signed [DataW-1:0] reference;
    logic signed [DataW-1:0] plant_out;
    logic signed [DataW-1:0] plant_der;
  } opnd_t;

  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] drive_value;
    logic [ModelW-1:0]       chosen_model;
  } res_t;

  // 2*N + D with N = 10*ref - a*out - b*deriv, scaled so the gains are integers.
  function automatic logic signed [NumW-1:0] num_calc(
    input logic [ModelW-1:0]       m,
    input logic signed [NumW-1:0]  r,
    input logic signed [NumW-1:0]  o,
    input logic signed [NumW-1:0]  d
  );
    logic signed [NumW-1:0] n;
    logic signed [NumW-1:0] den;
    case (m)
      Model1: begin
        n   = 39'sd10 * r - 39'sd6 * o - 39'sd2 * d;
        den = 39'sd20;
      end
      Model2: begin
        n   = 39'sd10 * r - o - 39'sd8 * d;
        den = 39'sd25;
      end
      default: begin
        n   = 39'sd10 * r - 39'sd2 * o - 39'sd5 * d;
        den = 39'sd10;
      end
    endcase
    return (n <<< 1) + den;
  endfunction

  // 2*D = 2^shift * odd
  function automatic logic [1:0] pre_shift(input logic [ModelW-1:0] m);
    logic [1:0] k;
    case (m)
      Model1:  k = 2'd3;
      Model2:  k = 2'd1;
      default: k = 2'd2;
    endcase
    return k;
  endfunction

  function automatic logic [OddW-1:0] odd_div(input logic [ModelW-1:0] m);
    return (m == Model2) ? OddW'(25) : OddW'(5);
  endfunction

  function automatic logic [RecipW-1:0] recip(input logic [ModelW-1:0] m);
    return (m == Model2) ? Recip25 : Recip5;
  endfunction

endpackage

### hw/rtl/mmsc_in_if.sv
// Sample channel: opcode and signed sample with valid/ready handshake.
interface mmsc_in_if import mmsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          opcode;
  logic signed [DataW-1:0] sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

### hw/rtl/mmsc_out_if.sv
// Drive channel: saturated drive and chosen model with valid/ready handshake.
interface mmsc_out_if import mmsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive_value;
  logic [ModelW-1:0]       chosen_model;

  modport source (output valid, output drive_value, output chosen_model, input ready);
  modport sink   (input valid, input drive_value, input chosen_model, output ready);
endinterface

### hw/rtl/multi_model_switching_controller.sv
// Top level of the multi-model switching controller.
//
// Usage:
//   sample_i takes one transaction per cycle while ready, each an opcode
//   and a signed Q16.16 value. Opcodes 0..2 fill the reference, plant output
//   and plant derivative holds (a hold already filled ignores further
//   writes); 3..5 overwrite the error of model 1..3; 6 and 7 do nothing.
//   When the third hold fills, drive_o gives one transaction: the drive
//   (ref - a*out - b*deriv)/c of the model with the smallest error (ties to
//   the lower number), rounded to nearest and saturated, with that model's
//   number. The holds are then released.
//   One transaction is accepted every cycle while no result waits on a
//   stalled drive_o, through a seven-register pipeline.
//   Reset clears the holds, the errors and all pipeline valids.
//   A stall on drive_o freezes the whole pipeline; sample_i.ready follows
//   drive_o.ready while a result waits.
module multi_model_switching_controller import mmsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmsc_in_if.sink     sample_i,
  mmsc_out_if.source  drive_o
);

  logic  en;
  in_t   in_q;
  opnd_t opnd;
  res_t  res;

  // advance everything unless a result is stuck at the output
  assign en             = !res.valid || drive_o.ready;
  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q.valid  <= sample_i.valid;
      in_q.opcode <= sample_i.opcode;
      in_q.value  <= sample_i.sample_value;
    end
  end

  mmsc_select u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (in_q),
    .opnd_o (opnd)
  );

  mmsc_drive u_drive (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .opnd_i (opnd),
    .res_o  (res)
  );

  assign drive_o.valid        = res.valid;
  assign drive_o.drive_value  = res.drive_value;
  assign drive_o.chosen_model = res.chosen_model;

endmodule

### hw/rtl/mmsc_select.sv
// Sample holds, model errors and minimum-error model choice.
module mmsc_select import mmsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  in_t   in_i,
  output opnd_t opnd_o
);

  logic signed [DataW-1:0] ref_q, ref_d;
  logic signed [DataW-1:0] out_q, out_d;
  logic signed [DataW-1:0] der_q, der_d;
  logic signed [DataW-1:0] err_q [3];
  logic signed [DataW-1:0] err_d [3];
  logic [2:0]              flags_q, flags_d, flags_set, flags_n;
  logic                    fire;
  logic [ModelW-1:0]       model;
  opnd_t                   opnd_q, opnd_d;

  always_comb begin
    ref_d     = ref_q;
    out_d     = out_q;
    der_d     = der_q;
    err_d     = err_q;
    flags_set = '0;
    if (in_i.valid) begin
      case (in_i.opcode)
        OpRef: begin
          if (!flags_q[FlagRef]) begin
            ref_d              = in_i.value;
            flags_set[FlagRef] = 1'b1;
          end
        end
        OpOut: begin
          if (!flags_q[FlagOut]) begin
            out_d              = in_i.value;
            flags_set[FlagOut] = 1'b1;
          end
        end
        OpDeriv: begin
          if (!flags_q[FlagDeriv]) begin
            der_d                = in_i.value;
            flags_set[FlagDeriv] = 1'b1;
          end
        end
        OpErr1:  err_d[0] = in_i.value;
        OpErr2:  err_d[1] = in_i.value;
        OpErr3:  err_d[2] = in_i.value;
        default: ;
      endcase
    end
    flags_n = flags_q | flags_set;
    fire    = in_i.valid && (flags_n == 3'b111);
    flags_d = fire ? 3'b000 : flags_n;

    // true minimum, ties to the lower model
    if (err_d[0] <= err_d[1] && err_d[0] <= err_d[2]) begin
      model = Model1;
    end else if (err_d[1] <= err_d[2]) begin
      model = Model2;
    end else begin
      model = Model3;
    end

    opnd_d.valid     = fire;
    opnd_d.model     = model;
    opnd_d.reference = ref_d;
    opnd_d.plant_out = out_d;
    opnd_d.plant_der = der_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q        <= '0;
      out_q        <= '0;
      der_q        <= '0;
      flags_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        err_q[i] <= '0;
      end
      opnd_q       <= '0;
    end else if (en_i) begin
      ref_q        <= ref_d;
      out_q        <= out_d;
      der_q        <= der_d;
      flags_q      <= flags_d;
      err_q        <= err_d;
      opnd_q       <= opnd_d;
    end
  end

  assign opnd_o = opnd_q;

  a_flags_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opnd_q.valid |-> (flags_q == 3'b000))
    else $error("held flags not cleared after a result");

  a_held_ref_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && flags_q[FlagRef] && !fire) |=> (flags_q[FlagRef] && $stable(ref_q)))
    else $error("held reference lost before a result");

  a_model1_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opnd_q.valid && opnd_q.model == Model1) |->
      (err_q[0] <= err_q[1] && err_q[0] <= err_q[2]))
    else $error("model 1 chosen without the smallest error");

  a_model2_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opnd_q.valid && opnd_q.model == Model2) |->
      (err_q[1] < err_q[0] && err_q[1] <= err_q[2]))
    else $error("model 2 chosen without the smallest error");

endmodule

### hw/rtl/mmsc_drive.sv
// Drive pipeline: numerator, clamp, two-digit reciprocal division, result register.
module mmsc_drive import mmsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  opnd_t opnd_i,
  output res_t  res_o
);

  // numerator stage
  logic                    v_num_q;
  logic [ModelW-1:0]       m_num_q;
  logic signed [NumW-1:0]  num_q, num_d;

  // clamp stage
  logic                    v_u_q;
  logic [ModelW-1:0]       m_u_q;
  logic [UW-1:0]           u_q, u_d;
  logic signed [NumW-1:0]  y_sh;
  logic signed [TW-1:0]    y_s, t_s;
  logic [TW-1:0]           off, lim;

  // high digit stage
  logic                    v_hi_q;
  logic [ModelW-1:0]       m_hi_q;
  logic [HiW-1:0]          uh_q;
  logic [SplitW-1:0]       ul_q;
  logic [QhW-1:0]          qh_q, qh_d;
  logic [HiW+RecipW-1:0]   prod_hi;

  // remainder stage
  logic                    v_rem_q;
  logic [ModelW-1:0]       m_rem_q;
  logic [QhW-1:0]          qh2_q;
  logic [X2W-1:0]          x2_q, x2_d;
  logic [HiW-1:0]          qd;
  logic [RemW-1:0]         rh;

  // result stage
  logic [X2W+RecipW-1:0]   prod_lo;
  logic [QlW-1:0]          ql;
  logic [DataW-1:0]        qfull;
  res_t                    res_q;

  assign num_d = num_calc(opnd_i.model,
                          NumW'(opnd_i.reference),
                          NumW'(opnd_i.plant_out),
                          NumW'(opnd_i.plant_der));

  // floor by 2^k, then offset by d*2^31 and clamp to [0, d*2^32 - 1]
  always_comb begin
    y_sh = num_q >>> pre_shift(m_num_q);
    y_s  = {{(TW-NumW){y_sh[NumW-1]}}, y_sh};
    off  = {{(TW-OddW){1'b0}}, odd_div(m_num_q)} << (DataW - 1);
    lim  = ({{(TW-OddW){1'b0}}, odd_div(m_num_q)} << DataW) - TW'(1);
    t_s  = y_s + $signed(off);
    if (t_s[TW-1]) begin
      u_d = '0;
    end else if ($unsigned(t_s) > lim) begin
      u_d = UW'(lim);
    end else begin
      u_d = UW'($unsigned(t_s));
    end
  end

  always_comb begin
    prod_hi = (HiW+RecipW)'(u_q[UW-1:SplitW]) * (HiW+RecipW)'(recip(m_u_q));
    qh_d    = prod_hi[RecipShift +: QhW];
  end

  always_comb begin
    qd   = HiW'(qh_q) * HiW'(odd_div(m_hi_q));
    rh   = RemW'(uh_q - qd);
    x2_d = {rh, ul_q};
  end

  always_comb begin
    prod_lo = (X2W+RecipW)'(x2_q) * (X2W+RecipW)'(recip(m_rem_q));
    ql      = prod_lo[RecipShift +: QlW];
    qfull   = DataW'({qh2_q, {SplitW{1'b0}}}) + DataW'(ql);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_num_q     <= 1'b0;
      v_u_q       <= 1'b0;
      v_hi_q      <= 1'b0;
      v_rem_q     <= 1'b0;
      res_q       <= '0;
    end else if (en_i) begin
      v_num_q            <= opnd_i.valid;
      v_u_q              <= v_num_q;
      v_hi_q             <= v_u_q;
      v_rem_q            <= v_hi_q;
      res_q.valid        <= v_rem_q;
      res_q.chosen_model <= m_rem_q;
      // undo the 2^31 offset
      res_q.drive_value  <= {~qfull[DataW-1], qfull[DataW-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_num_q            <= opnd_i.model;
      num_q              <= num_d;
      m_u_q              <= m_num_q;
      u_q                <= u_d;
      m_hi_q             <= m_u_q;
      uh_q               <= u_q[UW-1:SplitW];
      ul_q               <= u_q[SplitW-1:0];
      qh_q               <= qh_d;
      m_rem_q            <= m_hi_q;
      qh2_q              <= qh_q;
      x2_q               <= x2_d;
    end
  end

  assign res_o = res_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_rem_q |-> (x2_q[X2W-1:SplitW] < odd_div(m_rem_q)))
    else $error("digit remainder not below the divisor");

  a_model_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> (res_q.chosen_model != 2'd0))
    else $error("result carries no model number");

endmodule
